// ----- src/gscd_pkg.sv -----
package gscd_pkg;

  localparam int unsigned HASH_W      = 64;
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned PERIOD_W    = 4;
  localparam int unsigned PERIOD_MAX  = 15;
  localparam int unsigned RING_DEPTH  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HASH_W-1:0] FNV_BASIS       = 64'hcbf2_9ce4_8422_2325;
  localparam logic [8:0]        FNV_PRIME_LO    = 9'h1b3;
  localparam int unsigned       FNV_PRIME_SHIFT = 40;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_beat_t;

  // prime is 2^40 + 0x1b3: one shift plus a 64x9 product
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [CELL_W-1:0] b);
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] lo;
    x  = h ^ {{(HASH_W-CELL_W){1'b0}}, b};
    lo = x * {{(HASH_W-9){1'b0}}, FNV_PRIME_LO};
    return (x << FNV_PRIME_SHIFT) + lo;
  endfunction

endpackage

// ----- src/gscd_if.sv -----
interface gscd_in_if;
  logic                         valid;
  logic                         ready;
  logic [gscd_pkg::CELL_W-1:0]  cell_value;
  logic                         last_cell;

  modport source (output valid, output cell_value, output last_cell, input ready);
  modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

interface gscd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gscd_pkg::HASH_W-1:0]   generation_hash;
  logic                          cycle_found;
  logic [gscd_pkg::PERIOD_W-1:0] cycle_period;

  modport source (output valid, output generation_hash, output cycle_found,
                  output cycle_period, input ready);
  modport sink   (input valid, input generation_hash, input cycle_found,
                  input cycle_period, output ready);
endinterface

// ----- src/grid_state_cycle_detector_top.sv -----
// Cells: one beat per cycle while the hash queue is not full; the FNV-1a fold of each cell
// updates the registered running hash. After the last cell, the ring search reads back stored
// hashes newest first in alternating read and compare states, over up to F-1 entries and
// stopping at the first match, F = ring fill (1..RING_DEPTH). A two-entry hash queue lets
// hashing of the next generation overlap the search.
// Reset: asynchronous, active low; the ring memory is not cleared, a fill count tracks it.
module grid_state_cycle_detector_top #(
  parameter int unsigned RING_DEPTH = gscd_pkg::RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gscd_in_if.sink    in_i,
  gscd_out_if.source out_o
);

  gscd_pkg::hash_beat_t push, head;
  logic                 full, pop;

  gscd_hash_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  gscd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  gscd_ring_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ----- src/gscd_hash_front.sv -----
module gscd_hash_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gscd_in_if.sink              in_i,
  input  logic                 full_i,
  output gscd_pkg::hash_beat_t push_o
);

  logic [gscd_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [gscd_pkg::HASH_W-1:0] step;
  logic                        take;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign step       = gscd_pkg::fnv_step(hash_q, in_i.cell_value);

  assign push_o.valid = take && in_i.last_cell;
  assign push_o.hash  = step;

  always_comb begin
    hash_d = hash_q;
    if (take) begin
      hash_d = in_i.last_cell ? gscd_pkg::FNV_BASIS : step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= gscd_pkg::FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ----- src/gscd_queue.sv -----
module gscd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gscd_pkg::hash_beat_t push_i,
  output logic                 full_o,
  output gscd_pkg::hash_beat_t head_o,
  input  logic                 pop_i
);

  logic [gscd_pkg::HASH_W-1:0]   slot_q [gscd_pkg::QUEUE_DEPTH];
  logic [gscd_pkg::QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [gscd_pkg::QUEUE_CW-1:0] cnt_q;
  logic                          do_push, do_pop;

  assign full_o       = (cnt_q == gscd_pkg::QUEUE_CW'(gscd_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.hash  = slot_q[rptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [gscd_pkg::QUEUE_AW-1:0] nxt(
      input logic [gscd_pkg::QUEUE_AW-1:0] p);
    return (p == gscd_pkg::QUEUE_AW'(gscd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= nxt(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= nxt(rptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/gscd_ring_back.sv -----
module gscd_ring_back #(
  parameter int unsigned RING_DEPTH = gscd_pkg::RING_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gscd_pkg::hash_beat_t head_i,
  output logic                 pop_o,
  gscd_out_if.source           out_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } gscd_state_e;

  gscd_state_e                   state_q, state_d;
  logic [gscd_pkg::HASH_W-1:0]   ring [RING_DEPTH];
  logic [gscd_pkg::HASH_W-1:0]   rdata_q;
  logic [gscd_pkg::HASH_W-1:0]   newest_q, newest_d;
  logic [AW-1:0]                 wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]                 fill_q, fill_d, fill_new;
  logic [CW-1:0]                 j_q, j_d;
  logic                          found_q, found_d;
  logic [gscd_pkg::PERIOD_W-1:0] period_q, period_d;
  logic                          mem_we, rd_en, load;

  logic                          ovalid_q;
  logic [gscd_pkg::HASH_W-1:0]   ohash_q;
  logic                          ofound_q;
  logic [gscd_pkg::PERIOD_W-1:0] operiod_q;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [gscd_pkg::PERIOD_W-1:0] sat(input logic [CW-1:0] v);
    return (32'(v) > gscd_pkg::PERIOD_MAX) ? gscd_pkg::PERIOD_W'(gscd_pkg::PERIOD_MAX)
                                           : gscd_pkg::PERIOD_W'(v);
  endfunction

  assign fill_new = (fill_q == CW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    newest_d = newest_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    j_d      = j_q;
    found_d  = found_q;
    period_d = period_q;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    load     = 1'b0;
    pop_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          mem_we   = 1'b1;
          newest_d = head_i.hash;
          rp_d     = dec(wp_q);
          wp_d     = inc(wp_q);
          fill_d   = fill_new;
          j_d      = CW'(1);
          found_d  = 1'b0;
          period_d = '0;
          state_d  = (fill_new < CW'(2)) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata_q == newest_q) begin
          found_d  = 1'b1;
          period_d = sat(j_q);
          state_d  = S_DONE;
        end else if (j_q == fill_q - 1'b1) begin
          state_d = S_DONE;
        end else begin
          j_d     = j_q + 1'b1;
          rp_d    = dec(rp_q);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[wp_q] <= head_i.hash;
    end
    if (rd_en) begin
      rdata_q <= ring[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    rp_q     <= rp_d;
    j_q      <= j_d;
    found_q  <= found_d;
    period_q <= period_d;
    if (load) begin
      ohash_q   <= newest_q;
      ofound_q  <= found_q;
      operiod_q <= period_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.generation_hash = ohash_q;
  assign out_o.cycle_found     = ofound_q;
  assign out_o.cycle_period    = operiod_q;

endmodule

// ----- src/gscd_checker.sv -----
module gscd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [gscd_pkg::HASH_W-1:0]   out_hash_i,
  input logic                          out_found_i,
  input logic [gscd_pkg::PERIOD_W-1:0] out_period_i
);

  logic [7:0] pend_q;
  logic       gen_in, gen_out;

  assign gen_in  = in_valid_i && in_ready_i && in_last_i;
  assign gen_out = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({gen_in, gen_out})
        2'b10:   pend_q <= pend_q + 1'b1;
        2'b01:   pend_q <= pend_q - 1'b1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hash_i)
      && $stable(out_found_i) && $stable(out_period_i))
    else $error("result beat changed while stalled");

  a_found_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_found_i == (out_period_i != '0)))
    else $error("found flag and period disagree");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result beat without a finished generation");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'd4)
    else $error("too many generations in flight");

endmodule

bind grid_state_cycle_detector_top gscd_checker u_gscd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last_cell),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_hash_i   (out_o.generation_hash),
  .out_found_i  (out_o.cycle_found),
  .out_period_i (out_o.cycle_period)
);
